// ===== hdl/qrr_pkg.sv =====
// Package for the quota round-robin arbiter: sizes, codes, scan record and
// cell control types. No dependencies.
`default_nettype none
package qrr_pkg;

  localparam int unsigned NUM_ENTRIES = 8;
  localparam int unsigned IDX_W       = $clog2(NUM_ENTRIES);
  localparam int unsigned CNT_W       = $clog2(NUM_ENTRIES + 1);
  localparam int unsigned NUM_TAGGED  = 8;

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [3:0]       usage_t;

  localparam usage_t USAGE_MAX   = 4'd15;
  localparam usage_t QUOTA_RESET = 4'd4;

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_CHARGE = 2'd1,
    OP_SELECT = 2'd2,
    OP_NONE   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    CFG_QUOTA    = 2'd0,
    CFG_SPEC     = 2'd1,
    CFG_PRIORITY = 2'd2,
    CFG_SPARE    = 2'd3
  } cfg_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_e;

  typedef struct packed {
    usage_t quota;
    logic   urgent;
    idx_t   holder;
    logic   clear;
    logic   charge;
  } cell_ctrl_t;

  typedef struct packed {
    logic       pr_found;
    logic [3:0] pr_best;
    idx_t       pr_idx;
    logic       rr_hi_found;
    idx_t       rr_hi_idx;
    logic       rr_lo_found;
    idx_t       rr_lo_idx;
    logic [4:0] min_cnt;
    idx_t       min_idx;
  } scan_rec_t;

  function automatic logic [2:0] to_entry(idx_t idx);
    logic [31:0] wide;
    wide = 32'(idx);
    return wide[2:0];
  endfunction

endpackage
`default_nettype wire

// ===== hdl/qrr_if.sv =====
// Channel interfaces of the arbiter: request items in, decision items out.
// Depends on nothing.
`default_nettype none
interface qrr_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] operation;
  logic       urgent;

  modport source (output valid, output operation, output urgent, input ready);
  modport sink   (input valid, input operation, input urgent, output ready);
endinterface

interface qrr_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] chosen_entry;
  logic       by_priority;
  logic       quota_exhausted;
  logic [3:0] chosen_usage;

  modport source (output valid, output chosen_entry, output by_priority,
                  output quota_exhausted, output chosen_usage, input ready);
  modport sink   (input valid, input chosen_entry, input by_priority,
                  input quota_exhausted, input chosen_usage, output ready);
endinterface
`default_nettype wire

// ===== hdl/qrr_cell.sv =====
// One requester cell: holds its usage count and folds itself into the scan
// record handed on from its left neighbour. Depends on qrr_pkg.
`default_nettype none
module qrr_cell (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  qrr_pkg::cell_ctrl_t ctrl_i,
  input  qrr_pkg::idx_t      idx_i,
  input  wire                spec_i,
  input  wire  [3:0]         prio_i,
  input  qrr_pkg::scan_rec_t rec_i,
  output qrr_pkg::scan_rec_t rec_o,
  output qrr_pkg::usage_t    count_o
);

  qrr_pkg::usage_t    count_q, count_d;
  qrr_pkg::scan_rec_t rec_q, rec_d;
  logic               under;

  assign under = count_q < ctrl_i.quota;

  always_comb begin
    count_d = count_q;
    if (ctrl_i.clear) begin
      count_d = '0;
    end else if (ctrl_i.charge && (idx_i == ctrl_i.holder) &&
                 (count_q != qrr_pkg::USAGE_MAX)) begin
      count_d = count_q + 4'd1;
    end
  end

  always_comb begin
    rec_d = rec_i;
    if (ctrl_i.urgent && under && spec_i &&
        (!rec_i.pr_found || (prio_i > rec_i.pr_best))) begin
      rec_d.pr_found = 1'b1;
      rec_d.pr_best  = prio_i;
      rec_d.pr_idx   = idx_i;
    end
    if (!rec_i.rr_hi_found && under && (idx_i > ctrl_i.holder)) begin
      rec_d.rr_hi_found = 1'b1;
      rec_d.rr_hi_idx   = idx_i;
    end
    if (!rec_i.rr_lo_found && under) begin
      rec_d.rr_lo_found = 1'b1;
      rec_d.rr_lo_idx   = idx_i;
    end
    if ({1'b0, count_q} < rec_i.min_cnt) begin
      rec_d.min_cnt = {1'b0, count_q};
      rec_d.min_idx = idx_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rec_q <= rec_d;
  end

  assign rec_o   = rec_q;
  assign count_o = count_q;

endmodule
`default_nettype wire

// ===== hdl/quota_round_robin_priority_arbiter.sv =====
// Top level of the quota round-robin arbiter: configuration registers,
// sequencer, row of requester cells and output register.
// Depends on qrr_pkg, qrr_if and qrr_cell.
//
//   channel  dir  handshake     payload
//   in_i     in   valid/ready   operation, urgent
//   out_o    out  valid/ready   chosen_entry, by_priority, quota_exhausted, chosen_usage
//   cfg      in   cfg_we_i      cfg_idx_i, cfg_wdata_i
//
// Clear, charge and no-op items go from idle straight to the finish state; a
// select item first passes through the scan state while the scan record moves
// one cell per cycle along the row. One item is in work at a time; the next
// is taken while a finished result waits in the output register.
// Reset clears counts, holder, settings and control state at once, but not the
// scan records or output payload; a stalled output holds the sequencer in its final state.
`default_nettype none
module quota_round_robin_priority_arbiter (
  input  wire          clk_i,
  input  wire          rst_ni,
  qrr_in_if.sink       in_i,
  qrr_out_if.source    out_o,
  input  wire          cfg_we_i,
  input  wire  [1:0]   cfg_idx_i,
  input  wire  [31:0]  cfg_wdata_i
);

  localparam int unsigned N = qrr_pkg::NUM_ENTRIES;

  qrr_pkg::state_e     state_q, state_d;
  logic [qrr_pkg::CNT_W-1:0] scan_cnt_q, scan_cnt_d;
  qrr_pkg::usage_t     quota_q;
  logic [7:0]          spec_q;
  logic [31:0]         prio_q;
  qrr_pkg::idx_t       holder_q, holder_d;
  logic                hi_q;
  logic                by_prio_q, by_prio_d;
  logic                exh_q, exh_d;
  logic                out_valid_q;
  logic [2:0]          out_entry_q;
  logic                out_prio_q;
  logic                out_exh_q;
  qrr_pkg::usage_t     out_usage_q;

  logic                accept;
  logic                out_load;
  logic                scan_done;
  qrr_pkg::op_e        op;
  qrr_pkg::cell_ctrl_t ctrl;
  qrr_pkg::scan_rec_t  rec_init;
  qrr_pkg::scan_rec_t  recs [N];
  qrr_pkg::usage_t     counts [N];
  qrr_pkg::scan_rec_t  last;

  assign op     = qrr_pkg::op_e'(in_i.operation);
  assign accept = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quota_q <= qrr_pkg::QUOTA_RESET;
      spec_q  <= '0;
      prio_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (qrr_pkg::cfg_e'(cfg_idx_i))
        qrr_pkg::CFG_QUOTA:    quota_q <= cfg_wdata_i[3:0];
        qrr_pkg::CFG_SPEC:     spec_q  <= cfg_wdata_i[7:0];
        qrr_pkg::CFG_PRIORITY: prio_q  <= cfg_wdata_i;
        qrr_pkg::CFG_SPARE:    ;
      endcase
    end
  end

  always_comb begin
    ctrl.quota  = quota_q;
    ctrl.urgent = hi_q;
    ctrl.holder = holder_q;
    ctrl.clear  = accept && (op == qrr_pkg::OP_CLEAR);
    ctrl.charge = accept && (op == qrr_pkg::OP_CHARGE);
  end

  always_comb begin
    rec_init         = '0;
    rec_init.min_cnt = 5'd16;
  end

  for (genvar k = 0; k < N; k++) begin : g_cell
    logic spec;
    logic [3:0] prio;
    if (k < qrr_pkg::NUM_TAGGED) begin : g_tagged
      assign spec = spec_q[k];
      assign prio = prio_q[4*k +: 4];
    end else begin : g_plain
      assign spec = 1'b0;
      assign prio = 4'd0;
    end
    qrr_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (ctrl),
      .idx_i   (qrr_pkg::IDX_W'(k)),
      .spec_i  (spec),
      .prio_i  (prio),
      .rec_i   ((k == 0) ? rec_init : recs[(k == 0) ? 0 : k - 1]),
      .rec_o   (recs[k]),
      .count_o (counts[k])
    );
  end

  assign last      = recs[N-1];
  assign scan_done = (state_q == qrr_pkg::ST_SCAN) && (scan_cnt_q == '0);
  assign out_load  = (state_q == qrr_pkg::ST_FINISH) && (!out_valid_q || out_o.ready);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      qrr_pkg::ST_IDLE: begin
        if (accept) begin
          state_d = (op == qrr_pkg::OP_SELECT) ? qrr_pkg::ST_SCAN : qrr_pkg::ST_FINISH;
        end
      end
      qrr_pkg::ST_SCAN: begin
        if (scan_cnt_q == '0) begin
          state_d = qrr_pkg::ST_FINISH;
        end
      end
      qrr_pkg::ST_FINISH: begin
        if (out_load) begin
          state_d = qrr_pkg::ST_IDLE;
        end
      end
      default: state_d = qrr_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_i.ready = (state_q == qrr_pkg::ST_IDLE);
    scan_cnt_d = scan_cnt_q;
    holder_d   = holder_q;
    by_prio_d  = by_prio_q;
    exh_d      = exh_q;
    if (accept) begin
      scan_cnt_d = qrr_pkg::CNT_W'(N);
      by_prio_d  = 1'b0;
      exh_d      = 1'b0;
      if (op == qrr_pkg::OP_CLEAR) begin
        holder_d = '0;
      end
    end else if (state_q == qrr_pkg::ST_SCAN) begin
      scan_cnt_d = scan_cnt_q - 1'b1;
    end
    if (scan_done) begin
      priority if (last.pr_found) begin
        holder_d  = last.pr_idx;
        by_prio_d = 1'b1;
      end else if (last.rr_hi_found) begin
        holder_d = last.rr_hi_idx;
      end else if (last.rr_lo_found) begin
        holder_d = last.rr_lo_idx;
      end else begin
        holder_d = last.min_idx;
        exh_d    = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= qrr_pkg::ST_IDLE;
      scan_cnt_q  <= '0;
      holder_q    <= '0;
      hi_q        <= 1'b0;
      by_prio_q   <= 1'b0;
      exh_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      scan_cnt_q <= scan_cnt_d;
      holder_q   <= holder_d;
      by_prio_q  <= by_prio_d;
      exh_q      <= exh_d;
      if (accept) begin
        hi_q <= in_i.urgent;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_entry_q <= qrr_pkg::to_entry(holder_q);
      out_prio_q  <= by_prio_q;
      out_exh_q   <= exh_q;
      out_usage_q <= counts[holder_q];
    end
  end

  assign out_o.valid           = out_valid_q;
  assign out_o.chosen_entry    = out_entry_q;
  assign out_o.by_priority     = out_prio_q;
  assign out_o.quota_exhausted = out_exh_q;
  assign out_o.chosen_usage    = out_usage_q;

endmodule
`default_nettype wire

// ===== test/quota_round_robin_priority_arbiter_checker.sv =====
`timescale 1ns / 100ps
// Scoreboard for the quota round-robin arbiter: tracks register writes, predicts
// each decision item from the request items and compares it with the output.
// Depends on qrr_pkg and qrr_if.
module quota_round_robin_priority_arbiter_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  qrr_in_if           req_i,
  qrr_out_if          dec_i,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [31:0] cfg_wdata_i,
  output int          mismatches_o,
  output int          awaited_o,
  output int          selects_o,
  output int          overrides_o,
  output int          fallbacks_o
);

  typedef struct packed {
    logic [2:0]      entry;
    logic            by_priority;
    logic            exhausted;
    qrr_pkg::usage_t usage;
  } decision_t;

  qrr_pkg::usage_t quota_q;
  logic [7:0]      specialists_q;
  logic [31:0]     priorities_q;
  int unsigned     holder_q;
  qrr_pkg::usage_t usage_q [qrr_pkg::NUM_ENTRIES];
  decision_t       decision_queue [$];
  int              mismatch_count;
  int              select_count;
  int              override_count;
  int              fallback_count;

  assign mismatches_o = mismatch_count;
  assign selects_o    = select_count;
  assign overrides_o  = override_count;
  assign fallbacks_o  = fallback_count;

  function automatic decision_t arbitrate(qrr_pkg::op_e op, logic hi);
    decision_t   d;
    logic        found;
    int unsigned pick;
    int unsigned cand;
    int unsigned i;
    logic [3:0]  prio;
    logic [3:0]  best;
    logic [4:0]  least;
    d     = '0;
    found = 1'b0;
    pick  = 0;
    best  = '0;
    least = 5'd16;
    if (holder_q >= qrr_pkg::NUM_ENTRIES) holder_q = 0;
    case (op)
      qrr_pkg::OP_CLEAR: begin
        for (i = 0; i < qrr_pkg::NUM_ENTRIES; i++) usage_q[i] = '0;
        holder_q = 0;
      end
      qrr_pkg::OP_CHARGE: begin
        if (usage_q[holder_q] != qrr_pkg::USAGE_MAX) begin
          usage_q[holder_q] = usage_q[holder_q] + 4'd1;
        end
      end
      qrr_pkg::OP_SELECT: begin
        if (hi) begin
          for (i = 0; i < qrr_pkg::NUM_ENTRIES; i++) begin
            prio = (i < 8) ? priorities_q[4*i +: 4] : 4'd0;
            if (i < 8 && specialists_q[i] && usage_q[i] < quota_q &&
                (!found || prio > best)) begin
              best  = prio;
              pick  = i;
              found = 1'b1;
            end
          end
          d.by_priority = found;
        end
        if (!found) begin
          cand = (holder_q + 1) % qrr_pkg::NUM_ENTRIES;
          for (i = 0; i < qrr_pkg::NUM_ENTRIES && !found; i++) begin
            if (usage_q[cand] < quota_q) begin
              pick  = cand;
              found = 1'b1;
            end
            cand = (cand + 1) % qrr_pkg::NUM_ENTRIES;
          end
        end
        if (!found) begin
          for (i = 0; i < qrr_pkg::NUM_ENTRIES; i++) begin
            if ({1'b0, usage_q[i]} < least) begin
              least = {1'b0, usage_q[i]};
              pick  = i;
            end
          end
          d.exhausted = 1'b1;
        end
        holder_q = pick;
      end
      default: ;
    endcase
    d.entry = holder_q[2:0];
    d.usage = usage_q[holder_q];
    return d;
  endfunction

  task automatic check_field(string field, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", field, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    decision_t want;
    decision_t got;
    if (!rst_ni) begin
      quota_q       = qrr_pkg::QUOTA_RESET;
      specialists_q = '0;
      priorities_q  = '0;
      holder_q      = 0;
      for (int unsigned i = 0; i < qrr_pkg::NUM_ENTRIES; i++) usage_q[i] = '0;
      decision_queue.delete();
      mismatch_count = 0;
      select_count   = 0;
      override_count = 0;
      fallback_count = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          qrr_pkg::CFG_QUOTA:    quota_q       = cfg_wdata_i[3:0];
          qrr_pkg::CFG_SPEC:     specialists_q = cfg_wdata_i[7:0];
          qrr_pkg::CFG_PRIORITY: priorities_q  = cfg_wdata_i;
          default: ;
        endcase
      end
      if (dec_i.valid && dec_i.ready) begin
        got = {dec_i.chosen_entry, dec_i.by_priority, dec_i.quota_exhausted,
               dec_i.chosen_usage};
        if (decision_queue.size() == 0) begin
          $error("decision item with no prediction: entry %0d usage %0d",
                 got.entry, got.usage);
          mismatch_count++;
        end else begin
          want = decision_queue.pop_front();
          check_field("chosen_entry", want.entry, got.entry);
          check_field("by_priority", want.by_priority, got.by_priority);
          check_field("quota_exhausted", want.exhausted, got.exhausted);
          check_field("chosen_usage", want.usage, got.usage);
        end
      end
      if (req_i.valid && req_i.ready) begin
        want = arbitrate(qrr_pkg::op_e'(req_i.operation), req_i.urgent);
        if (qrr_pkg::op_e'(req_i.operation) == qrr_pkg::OP_SELECT) select_count++;
        if (want.by_priority) override_count++;
        if (want.exhausted) fallback_count++;
        decision_queue.push_back(want);
      end
    end
    awaited_o <= decision_queue.size();
  end

endmodule

// ===== test/quota_round_robin_priority_arbiter_tb.sv =====
`timescale 1ns / 100ps
// Testbench top for the quota round-robin arbiter: clock, reset, request and
// register stimulus, output back-pressure, watchdog and verdict.
// Depends on qrr_pkg, qrr_if, the arbiter and its checker.
module quota_round_robin_priority_arbiter_tb;

  localparam int IDLE_LIMIT      = 4000;
  localparam int RANDOM_PHASES   = 12;
  localparam int ITEMS_PER_PHASE = 150;
  localparam int DRAIN_MARGIN    = 2 * qrr_pkg::NUM_ENTRIES + 4;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [1:0]  cfg_idx_i;
  logic [31:0] cfg_wdata_i;
  logic        calm;
  int          mismatches;
  int          awaited;
  int          selects;
  int          overrides;
  int          fallbacks;
  int          sent;
  int          settings;
  int          quiet_cycles = 0;

  qrr_in_if  req_ch ();
  qrr_out_if dec_ch ();

  quota_round_robin_priority_arbiter dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (req_ch),
    .out_o       (dec_ch),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  quota_round_robin_priority_arbiter_checker chk (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_i        (req_ch),
    .dec_i        (dec_ch),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .mismatches_o (mismatches),
    .awaited_o    (awaited),
    .selects_o    (selects),
    .overrides_o  (overrides),
    .fallbacks_o  (fallbacks)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    calm = 1'b0;
    forever begin
      repeat ($urandom_range(100, 600)) @(negedge clk_i);
      calm = ($urandom_range(0, 3) == 0);
    end
  end

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic qrr_pkg::op_e pick_op(int charge_pct);
    int r;
    r = $urandom_range(0, 99);
    if (r < 3) return qrr_pkg::OP_CLEAR;
    if (r < 8) return qrr_pkg::OP_NONE;
    if (r < 8 + charge_pct) return qrr_pkg::OP_CHARGE;
    return qrr_pkg::OP_SELECT;
  endfunction

  task automatic drain();
    req_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (awaited != 0) @(posedge clk_i);
    repeat (DRAIN_MARGIN) @(posedge clk_i);
  endtask

  task automatic send(qrr_pkg::op_e op, logic hi);
    int gap;
    req_ch.valid     <= 1'b1;
    req_ch.operation <= op;
    req_ch.urgent    <= hi;
    do @(posedge clk_i); while (!req_ch.ready);
    sent++;
    if ($urandom_range(0, 199) == 0) begin
      drain();
    end else begin
      gap = idle_len();
      if (gap > 0) begin
        req_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  task automatic set_reg(qrr_pkg::cfg_e idx, logic [31:0] value);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Upper bits carry junk, which the block must drop.
  task automatic configure(logic [3:0] quota, logic [7:0] mask, logic [31:0] prio);
    logic [31:0] junk;
    junk = $urandom;
    set_reg(qrr_pkg::CFG_QUOTA, {junk[31:4], quota});
    junk = $urandom;
    set_reg(qrr_pkg::CFG_SPEC, {junk[31:8], mask});
    set_reg(qrr_pkg::CFG_PRIORITY, prio);
    if ($urandom_range(0, 1) == 1) set_reg(qrr_pkg::CFG_SPARE, $urandom);
    settings++;
  endtask

  initial begin
    dec_ch.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      int gap;
      gap = idle_len();
      if (gap > 0) begin
        dec_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      dec_ch.ready <= 1'b1;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (req_ch.valid && req_ch.ready) || (dec_ch.valid && dec_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= IDLE_LIMIT) begin
      $display("quota_round_robin_priority_arbiter verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int          charge_pct;
    logic [3:0]  quota;
    logic [7:0]  mask;
    logic [31:0] prio;
    sent     = 0;
    settings = 1;
    rst_ni           <= 1'b0;
    cfg_we_i         <= 1'b0;
    cfg_idx_i        <= qrr_pkg::CFG_QUOTA;
    cfg_wdata_i      <= '0;
    req_ch.valid     <= 1'b0;
    req_ch.operation <= qrr_pkg::OP_NONE;
    req_ch.urgent    <= 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send(qrr_pkg::OP_CLEAR, 1'b0);
    send(qrr_pkg::OP_NONE, 1'b1);
    for (int k = 0; k < 16; k++) send(qrr_pkg::OP_CHARGE, k[0]);
    send(qrr_pkg::OP_SELECT, 1'b1);
    send(qrr_pkg::OP_SELECT, 1'b0);
    drain();
    configure(4'd0, 8'h81, 32'hF000_000F);
    send(qrr_pkg::OP_SELECT, 1'b1);
    drain();
    configure(4'd15, 8'h81, 32'hF000_000F);
    send(qrr_pkg::OP_SELECT, 1'b1);
    drain();
    configure(4'd15, 8'hC0, 32'h5500_0000);
    send(qrr_pkg::OP_SELECT, 1'b1);

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      drain();
      case (ph)
        0: begin quota = 4'd1;  mask = 8'hFF; prio = 32'h0;        end
        1: begin quota = 4'd15; mask = 8'h00; prio = 32'hFFFF_FFFF; end
        2: begin quota = 4'd0;  mask = 8'($urandom); prio = $urandom; end
        3: begin quota = 4'd15; mask = 8'hFF; prio = 32'hFFFF_FFFF; end
        4: begin
          quota = 4'd2;
          mask  = 8'($urandom);
          prio  = {8{4'($urandom)}};
        end
        default: begin
          quota = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15))
                                              : 4'($urandom_range(1, 5));
          mask  = 8'($urandom);
          prio  = $urandom;
        end
      endcase
      configure(quota, mask, prio);
      charge_pct = $urandom_range(30, 70);
      repeat (ITEMS_PER_PHASE) send(pick_op(charge_pct), 1'($urandom_range(0, 1)));
    end

    drain();
    $display("Sent %0d request items under %0d register settings.", sent, settings);
    $display("Selections %0d: %0d by priority override, %0d least-used fallbacks.",
             selects, overrides, fallbacks);
    if (mismatches == 0 && awaited == 0) begin
      $display("quota_round_robin_priority_arbiter verification clean");
    end else begin
      $display("quota_round_robin_priority_arbiter verification failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hdl/qrr_pkg.sv
hdl/qrr_if.sv
hdl/qrr_cell.sv
hdl/quota_round_robin_priority_arbiter.sv
test/quota_round_robin_priority_arbiter_checker.sv
test/quota_round_robin_priority_arbiter_tb.sv
